// ===== rtl/core/lfba_pkg.sv =====
// lfba_pkg: shared types and constants for the lowest free block allocator
// no dependencies; imported by every module of the block except lfba_ram
package lfba_pkg;

	localparam int NUM_BLOCKS    = 32768;
	localparam int TIME_BITS     = 16;
	localparam int IDX_W         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W         = $clog2(NUM_BLOCKS + 1);
	localparam int TIMEOUT_W     = 16;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd600;

	// register addresses, word index taken from paddr[2]
	localparam logic REG_IDLE_TIMEOUT = 1'b0;

	// request modes
	localparam logic MODE_ALLOC  = 1'b0;
	localparam logic MODE_ACCESS = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [15:0] current_time;
		logic [15:0] block_number;
	} in_item_t;

	typedef struct packed {
		logic        granted;
		logic [15:0] allocated_block;
	} out_item_t;

	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [IDX_W-1:0]     addr;
		logic [TIME_BITS-1:0] wdata;
	} mem_req_t;

endpackage

// ===== rtl/core/lowest_free_block_allocator_timeout.sv =====
// lowest_free_block_allocator_timeout: top level, apb register, stamp memory, sequencer
// depends on lfba_pkg, lfba_ram, lfba_age, lfba_seq
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    in_data  (lfba_pkg::in_item_t)
//  out       source     out_valid / out_ready  out_data (lfba_pkg::out_item_t)
//  cfg       apb slave  psel, penable, pready  paddr, pwdata, prdata
//
// an access transaction goes from accept to out_valid through stamp read, age check, result
// (a block number outside the pool skips the stamp read and the age check)
// an allocate transaction scans the taken blocks upward from the lowest, one stamp per cycle
// through the single read port of the stamp memory, and grants the first expired one it finds,
// else the next untaken block, else nothing when no block is free
// reset clears the fill count but not the stamp memory, so no clearing pass is needed after reset
// in_ready is high only while no transaction is in flight; a result waiting on out_ready
// stalls the next one only at its final step
module lowest_free_block_allocator_timeout (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lfba_pkg::in_item_t                  in_data,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output lfba_pkg::out_item_t                 out_data,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lfba_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [lfba_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [lfba_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import lfba_pkg::*;

	// idle timeout register
	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 reg_sel;

	// stamp memory and age unit wiring
	mem_req_t             mem_req;
	logic [TIME_BITS-1:0] rd_data;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] stamp;
	logic                 age_live;

	// apb: zero wait states, word select from paddr[2]
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_IDLE_TIMEOUT);
	assign prdata  = reg_sel ? APB_DATA_W'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			timeout_q <= pwdata[TIMEOUT_W-1:0];
		end
	end

	// last access stamp per block, never cleared; stamps at or above the fill count are ignored
	lfba_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_stamp_ram (
		.clk   (clk),
		.rd_en (mem_req.rd_en),
		.wr_en (mem_req.wr_en),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rd_data)
	);

	// one age compare, shared by the allocate scan and the access check
	lfba_age u_age (
		.now     (now),
		.stamp   (stamp),
		.timeout (timeout_q),
		.live    (age_live)
	);

	// sequencer: scan for lowest free block or check one block
	lfba_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.now       (now),
		.stamp     (stamp),
		.age_live  (age_live)
	);

endmodule

// ===== rtl/core/lfba_ram.sv =====
// lfba_ram: generic single-port ram with registered read data
// no dependencies
module lfba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                         clk,
	input  logic                                         rd_en,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                             wdata,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/core/lfba_age.sv =====
// lfba_age: shared age compare, wrapping (now - stamp) against the idle timeout
// depends on lfba_pkg
module lfba_age (
	input  logic [lfba_pkg::TIME_BITS-1:0] now,
	input  logic [lfba_pkg::TIME_BITS-1:0] stamp,
	input  logic [lfba_pkg::TIMEOUT_W-1:0] timeout,
	output logic                           live
);
	import lfba_pkg::*;

	logic [TIME_BITS-1:0] age;

	// subtraction wraps modulo 2^TIME_BITS
	assign age  = now - stamp;
	assign live = (32'(age) < 32'(timeout));

endmodule

// ===== rtl/core/lfba_seq.sv =====
// lfba_seq: request sequencer, fill count, stamp memory control and result register
// depends on lfba_pkg; drives lfba_ram through a mem_req_t and uses lfba_age
module lfba_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lfba_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output lfba_pkg::out_item_t            out_data,
	output lfba_pkg::mem_req_t             mem_req,
	input  logic [lfba_pkg::TIME_BITS-1:0] rd_data,
	output logic [lfba_pkg::TIME_BITS-1:0] now,
	output logic [lfba_pkg::TIME_BITS-1:0] stamp,
	input  logic                           age_live
);
	import lfba_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_ACC_CHK = 3'd2;
	localparam logic [2:0] S_FIN     = 3'd3;

	logic [2:0]       state_q;
	in_item_t         req_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_q;
	logic             chk_vld_q;
	logic [IDX_W-1:0] chk_idx_q;
	out_item_t        res_q;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             in_ok;
	logic [IDX_W-1:0] in_idx;
	logic [IDX_W-1:0] req_idx;
	logic             acc_live;
	logic             found_exp;
	logic             more_taken;
	logic             room;
	logic             fin_go;

	// blocks are always taken as a prefix, so taken means index below fill_q
	assign in_ok   = (in_data.block_number != 16'd0) &&
	                 (32'(in_data.block_number) <= 32'(NUM_BLOCKS));
	assign in_idx  = IDX_W'(in_data.block_number - 16'd1);
	assign req_idx = IDX_W'(req_q.block_number - 16'd1);

	assign now      = TIME_BITS'(req_q.current_time);
	assign stamp    = rd_data;
	assign acc_live = (32'(req_idx) < 32'(fill_q)) && age_live;

	assign found_exp  = chk_vld_q && !age_live;
	assign more_taken = (scan_q < fill_q);
	assign room       = (32'(fill_q) < 32'(NUM_BLOCKS));

	// result register is free or being emptied this cycle
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		mem_req = '0;
		mem_req.wdata = now;
		case (state_q)
			S_IDLE: begin
				mem_req.addr = in_idx;
				mem_req.rd_en = in_valid && (in_data.mode == MODE_ACCESS) && in_ok;
			end
			S_ACC_CHK: begin
				mem_req.addr = req_idx;
				mem_req.wr_en = acc_live;
			end
			S_SCAN: begin
				if (found_exp) begin
					mem_req.addr = chk_idx_q;
					mem_req.wr_en = 1'b1;
				end else if (more_taken) begin
					mem_req.addr = scan_q[IDX_W-1:0];
					mem_req.rd_en = 1'b1;
				end else begin
					mem_req.addr = fill_q[IDX_W-1:0];
					mem_req.wr_en = room;
				end
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			chk_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q <= '0;
						if (in_data.mode == MODE_ALLOC) begin
							scan_q    <= '0;
							chk_vld_q <= 1'b0;
							state_q   <= S_SCAN;
						end else if (in_ok) begin
							state_q <= S_ACC_CHK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_ACC_CHK: begin
					res_q.granted <= acc_live;
					state_q       <= S_FIN;
				end
				S_SCAN: begin
					if (found_exp) begin
						res_q.granted         <= 1'b1;
						res_q.allocated_block <= 16'(32'(chk_idx_q) + 32'd1);
						chk_vld_q             <= 1'b0;
						state_q               <= S_FIN;
					end else if (more_taken) begin
						chk_vld_q <= 1'b1;
						chk_idx_q <= scan_q[IDX_W-1:0];
						scan_q    <= scan_q + CNT_W'(1);
					end else begin
						chk_vld_q <= 1'b0;
						if (room) begin
							res_q.granted         <= 1'b1;
							res_q.allocated_block <= 16'(32'(fill_q) + 32'd1);
							fill_q                <= fill_q + CNT_W'(1);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						out_data_q <= res_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(NUM_BLOCKS))
		else $error("fill count above pool size");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("fill count moved by more than one");

	a_chk_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && chk_vld_q) |-> (32'(chk_idx_q) < 32'(fill_q)))
		else $error("scan checked an untaken block");

	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (state_q == S_SCAN || state_q == S_ACC_CHK))
		else $error("stamp write outside scan or access check");

endmodule
